FILE: hw/rtl/bpa_pkg.sv
`timescale 1ns / 1ps
package bpa_pkg;

   localparam int MAX_BLOCKS_DEF = 64;
   localparam int OFFSET_BITS    = 20;
   localparam int SIZE_BITS      = 21;
   localparam int NEED_BITS      = 32;

   typedef enum logic [1:0] {
      OP_ALLOC = 2'd0,
      OP_FREE  = 2'd1,
      OP_MERGE = 2'd2,
      OP_NOP   = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_ALIGN,
      ST_APPEND,
      ST_MERGE,
      ST_MERGE_END,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic                   used;
      logic [SIZE_BITS-1:0]   size;
      logic [SIZE_BITS-1:0]   start;
   } entry_type;

   typedef struct packed {
      logic [19:0]            free_offset;
      logic [4:0]             align_log2;
      logic [SIZE_BITS-1:0]   request_bytes;
      op_type                 opcode;
   } req_type;

   typedef struct packed {
      logic [SIZE_BITS-1:0]   total_bytes;
      logic [SIZE_BITS-1:0]   available_bytes;
      logic [19:0]            block_offset;
      logic                   status;
   } result_type;

endpackage

FILE: hw/rtl/bpa_table.sv
`timescale 1ns / 1ps
module bpa_table #(
   parameter int  DEPTH = bpa_pkg::MAX_BLOCKS_DEF,
   parameter int  WIDTH = $bits(bpa_pkg::entry_type),
   localparam int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/bpa_engine.sv
`timescale 1ns / 1ps
module bpa_engine #(
   parameter int  MAX_BLOCKS = bpa_pkg::MAX_BLOCKS_DEF,
   localparam int IW = $clog2(MAX_BLOCKS),
   localparam int CW = $clog2(MAX_BLOCKS + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [bpa_pkg::SIZE_BITS-1:0] pool_bytes,
   input  logic                          req_valid,
   input  bpa_pkg::req_type              req,
   output logic                          req_ready,
   input  logic                          rsp_free,
   output logic                          done,
   output bpa_pkg::result_type           result,
   output logic                          wr_en,
   output logic [IW-1:0]                 wr_addr,
   output bpa_pkg::entry_type            wr_data,
   output logic                          rd_en,
   output logic [IW-1:0]                 rd_addr,
   input  bpa_pkg::entry_type            rd_data
);

   import bpa_pkg::*;

   localparam int EW  = SIZE_BITS + 1;
   localparam int AEW = NEED_BITS + 1;

   state_type              state_ff, state_in;
   op_type                 op_ff, op_in;
   logic [NEED_BITS-1:0]   need_ff, need_in;
   logic [NEED_BITS-1:0]   mask_ff, mask_in;
   logic [19:0]            off_ff, off_in;
   logic [CW-1:0]          issue_ff, issue_in;
   logic                   rd_valid_ff, rd_valid_in;
   logic [CW-1:0]          data_idx_ff, data_idx_in;
   logic [EW-1:0]          end_ff, end_in;
   logic [AEW-1:0]         end_al_ff, end_al_in;
   logic [IW-1:0]          wp_ff, wp_in;
   entry_type              acc_ff, acc_in;
   logic [CW-1:0]          count_ff, count_in;
   logic [SIZE_BITS-1:0]   used_ff, used_in;
   logic                   status_ff, status_in;
   logic [19:0]            offset_ff, offset_in;

   entry_type              entry;
   logic [EW-1:0]          span;
   logic [AEW:0]           append_end;
   logic [NEED_BITS-1:0]   new_mask;
   logic                   last;
   logic                   exhausted;
   logic                   hit;
   logic                   more;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         rd_valid_ff <= 1'b0;
         count_ff    <= '0;
         used_ff     <= '0;
      end else begin
         state_ff    <= state_in;
         rd_valid_ff <= rd_valid_in;
         if (csr_we) begin
            count_ff <= '0;
            used_ff  <= '0;
         end else begin
            count_ff <= count_in;
            used_ff  <= used_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      need_ff     <= need_in;
      mask_ff     <= mask_in;
      off_ff      <= off_in;
      issue_ff    <= issue_in;
      data_idx_ff <= data_idx_in;
      end_ff      <= end_in;
      end_al_ff   <= end_al_in;
      wp_ff       <= wp_in;
      acc_ff      <= acc_in;
      status_ff   <= status_in;
      offset_ff   <= offset_in;
   end

   always_comb begin
      entry      = rd_data;
      span       = {1'b0, entry.start} + {1'b0, entry.size};
      append_end = {1'b0, end_al_ff} + {2'b0, need_ff};
      new_mask   = (NEED_BITS'(1) << req.align_log2) - NEED_BITS'(1);
      last       = (data_idx_ff == count_ff - CW'(1));
      exhausted  = !rd_valid_ff && (issue_ff == count_ff);
      more       = (issue_ff < count_ff);
      hit        = 1'b0;

      state_in    = state_ff;
      op_in       = op_ff;
      need_in     = need_ff;
      mask_in     = mask_ff;
      off_in      = off_ff;
      issue_in    = issue_ff;
      rd_valid_in = 1'b0;
      data_idx_in = issue_ff;
      end_in      = end_ff;
      end_al_in   = end_al_ff;
      wp_in       = wp_ff;
      acc_in      = acc_ff;
      count_in    = count_ff;
      used_in     = used_ff;
      status_in   = status_ff;
      offset_in   = offset_ff;

      req_ready = 1'b0;
      done      = 1'b0;
      wr_en     = 1'b0;
      wr_addr   = data_idx_ff[IW-1:0];
      wr_data   = entry;
      rd_en     = 1'b0;
      rd_addr   = issue_ff[IW-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op_in     = req.opcode;
               mask_in   = new_mask;
               need_in   = ({{(NEED_BITS-SIZE_BITS){1'b0}}, req.request_bytes} + new_mask)
                           & ~new_mask;
               off_in    = req.free_offset;
               issue_in  = '0;
               end_in    = '0;
               wp_in     = '0;
               status_in = 1'b0;
               offset_in = '0;
               unique case (req.opcode)
                  OP_ALLOC: begin
                     if (pool_bytes == '0 || req.request_bytes == '0) begin
                        status_in = 1'b1;
                        state_in  = ST_DONE;
                     end else begin
                        state_in = ST_SCAN;
                     end
                  end
                  OP_FREE: begin
                     state_in = ST_SCAN;
                  end
                  OP_MERGE: begin
                     state_in = (count_ff < CW'(2)) ? ST_DONE : ST_MERGE;
                  end
                  OP_NOP: begin
                     state_in = ST_DONE;
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end

         ST_SCAN: begin
            if (rd_valid_ff) begin
               if (op_ff == OP_ALLOC) begin
                  hit = !entry.used &&
                        ({{(NEED_BITS-SIZE_BITS){1'b0}}, entry.size} >= need_ff);
                  if (hit) begin
                     wr_en        = 1'b1;
                     wr_data.used = 1'b1;
                     used_in      = used_ff + entry.size;
                     offset_in    = entry.start[19:0];
                     state_in     = ST_DONE;
                  end else if (span > end_ff) begin
                     end_in = span;
                  end
               end else begin
                  hit = entry.used && (entry.start == {1'b0, off_ff});
                  if (hit) begin
                     wr_en        = 1'b1;
                     wr_data.used = 1'b0;
                     used_in      = (used_ff >= entry.size) ? used_ff - entry.size : '0;
                     state_in     = ST_DONE;
                  end
               end
            end else if (exhausted) begin
               state_in = (op_ff == OP_ALLOC) ? ST_ALIGN : ST_DONE;
            end
            rd_en       = !hit && more;
            rd_valid_in = rd_en;
            issue_in    = issue_ff + CW'(rd_en);
         end

         ST_ALIGN: begin
            end_al_in = ({{(AEW-EW){1'b0}}, end_ff} + {1'b0, mask_ff}) & ~{1'b0, mask_ff};
            state_in  = ST_APPEND;
         end

         ST_APPEND: begin
            if (append_end > {{(AEW+1-SIZE_BITS){1'b0}}, pool_bytes} ||
                count_ff == CW'(MAX_BLOCKS) ||
                end_al_ff >= (AEW'(1) << OFFSET_BITS)) begin
               status_in = 1'b1;
            end else begin
               wr_en     = 1'b1;
               wr_addr   = count_ff[IW-1:0];
               wr_data   = '{used: 1'b1, size: need_ff[SIZE_BITS-1:0],
                             start: end_al_ff[SIZE_BITS-1:0]};
               count_in  = count_ff + CW'(1);
               used_in   = used_ff + need_ff[SIZE_BITS-1:0];
               offset_in = end_al_ff[19:0];
            end
            state_in = ST_DONE;
         end

         ST_MERGE: begin
            rd_en       = more;
            rd_valid_in = rd_en;
            issue_in    = issue_ff + CW'(rd_en);
            if (rd_valid_ff) begin
               if (data_idx_ff == '0) begin
                  acc_in = entry;
               end else if (!acc_ff.used && !entry.used) begin
                  acc_in.size = acc_ff.size + entry.size;
               end else begin
                  wr_en   = 1'b1;
                  wr_addr = wp_ff;
                  wr_data = acc_ff;
                  wp_in   = wp_ff + IW'(1);
                  acc_in  = entry;
               end
               if (last) begin
                  state_in = ST_MERGE_END;
               end
            end
         end

         ST_MERGE_END: begin
            wr_en    = 1'b1;
            wr_addr  = wp_ff;
            wr_data  = acc_ff;
            count_in = CW'(wp_ff) + CW'(1);
            state_in = ST_DONE;
         end

         ST_DONE: begin
            done = 1'b1;
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign result.status          = status_ff;
   assign result.block_offset    = offset_ff;
   assign result.available_bytes = (pool_bytes >= used_ff) ? pool_bytes - used_ff : '0;
   assign result.total_bytes     = pool_bytes;

endmodule

FILE: hw/rtl/block_pool_allocator.sv
`timescale 1ns / 1ps
// Block pool allocator: first-fit allocation with bump append over a table of
// blocks kept in address order, held in one synchronous table memory.
// Request words (req_) carry an allocate, free, merge or no-op; each gives
// exactly one response word (rsp_) with status, offset and available/total bytes.
// csr_we/csr_wdata set the pool size (rounded up to 256 bytes) and empty the
// table; write it only while no request is in flight.
// Allocate and free read one table entry per cycle, scanning up to count
// entries (count = blocks in the table, up to MAX_BLOCKS), and go through an
// align and append check when no free block fits. A merge walks the whole
// table once. Zero-size, no-pool and no-op requests, and merges of fewer than
// two blocks, go straight to the response without reading the table. One
// request is worked at a time; the engine returns to idle as the response word
// is loaded and only then takes the next one.
// The response sits in an output register; the next request is taken while it
// waits, and a finished result holds inside until the register frees.
// Reset empties the table, clears the pool size and drops any pending word;
// the table memory itself is not cleared, entries beyond the count are unused.
module block_pool_allocator #(
   parameter int MAX_BLOCKS = bpa_pkg::MAX_BLOCKS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // opcode[1:0], request_bytes[22:2], align_log2[27:23], free_offset[47:28]
   input  logic [47:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // status[0], block_offset[20:1], available_bytes[41:21], total_bytes[62:42]
   output logic [63:0] rsp_tdata,
   input  logic        csr_we,
   input  logic [20:0] csr_wdata
);

   import bpa_pkg::*;

   localparam int IW = $clog2(MAX_BLOCKS);

   logic [SIZE_BITS-1:0] pool_ff;
   logic [SIZE_BITS:0]   pool_round;
   logic                 rsp_valid_ff, rsp_valid_in;
   result_type           rsp_data_ff, rsp_data_in;
   logic                 rsp_free;
   logic                 done;
   result_type           result;
   logic                 wr_en;
   logic [IW-1:0]        wr_addr;
   entry_type            wr_data;
   logic                 rd_en;
   logic [IW-1:0]        rd_addr;
   entry_type            rd_data;

   assign pool_round = ({1'b0, csr_wdata} + (SIZE_BITS+1)'(255)) & ~(SIZE_BITS+1)'(255);

   always_ff @(posedge clock) begin
      if (reset) begin
         pool_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            pool_ff <= pool_round[SIZE_BITS] ? 21'h1FFF00 : pool_round[SIZE_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      rsp_free     = !rsp_valid_ff || rsp_tready;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (done && rsp_free) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_data_ff};

   bpa_engine #(
      .MAX_BLOCKS (MAX_BLOCKS)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .pool_bytes (pool_ff),
      .req_valid  (req_tvalid),
      .req        (req_tdata),
      .req_ready  (req_tready),
      .rsp_free   (rsp_free),
      .done       (done),
      .result     (result),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data)
   );

   bpa_table #(
      .DEPTH (MAX_BLOCKS),
      .WIDTH ($bits(entry_type))
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

endmodule
